### rtl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/lat_pkg.sv
// Types, action codes and helpers for the largest allocation tracker.
// Depends on nothing; used by lat_cell and largest_allocation_tracker.
package lat_pkg;

   localparam int RANK_W = 4;

   typedef enum logic [1:0] {
      ACT_RECORD = 2'd0,
      ACT_READ   = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef struct packed {
      logic [63:0] bytes;
      logic [31:0] want_type;
      logic [31:0] want_usage;
      logic [31:0] want_access;
      logic [31:0] got_type;
      logic [31:0] got_usage;
      logic [31:0] got_access;
      logic [63:0] align;
      logic [63:0] address;
      logic [31:0] seq;
   } entry_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  slot;
      logic [63:0] alloc_bytes;
      logic [31:0] want_mem_type;
      logic [31:0] want_usage;
      logic [31:0] want_access;
      logic [31:0] got_mem_type;
      logic [31:0] got_usage;
      logic [31:0] got_access;
      logic [63:0] align_bytes;
      logic [63:0] buffer_address;
   } req_type;

   typedef struct packed {
      logic [63:0]       out_bytes;
      logic [31:0]       out_want_type;
      logic [31:0]       out_want_usage;
      logic [31:0]       out_want_access;
      logic [31:0]       out_got_type;
      logic [31:0]       out_got_usage;
      logic [31:0]       out_got_access;
      logic [63:0]       out_align;
      logic [63:0]       out_address;
      logic [31:0]       out_sequence;
      logic [RANK_W-1:0] rank_taken;
      logic              peak_replaced;
   } rsp_type;

   // Per-cell control for one accepted request.
   typedef struct packed {
      logic record;
      logic clear;
      logic rd_hit;
   } cell_ctl_type;

   function automatic rsp_type entry_to_rsp(entry_type e);
      rsp_type r;
      r                 = '0;
      r.out_bytes       = e.bytes;
      r.out_want_type   = e.want_type;
      r.out_want_usage  = e.want_usage;
      r.out_want_access = e.want_access;
      r.out_got_type    = e.got_type;
      r.out_got_usage   = e.got_usage;
      r.out_got_access  = e.got_access;
      r.out_align       = e.align;
      r.out_address     = e.address;
      r.out_sequence    = e.seq;
      return r;
   endfunction

endpackage

### rtl/lat_cell.sv
// One ranked table cell: holds an entry, compares it with a new event and
// either keeps it, takes the new event or takes its upper neighbor's entry.
// Depends on lat_pkg.
module lat_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lat_pkg::cell_ctl_type ctl,
   input  lat_pkg::entry_type    new_entry,
   input  logic                  prev_gt,
   input  lat_pkg::entry_type    prev_entry,
   output logic                  gt,
   output lat_pkg::entry_type    entry,
   output lat_pkg::entry_type    rd_data
);
   import lat_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // The table is kept in non-increasing order, so the compare results form a
   // thermometer: once the new size beats a cell, it beats every cell below.
   assign gt      = new_entry.bytes > entry_ff.bytes;
   assign entry   = entry_ff;
   assign rd_data = ctl.rd_hit ? entry_ff : '0;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.clear) begin
         entry_in = '0;
      end else if (ctl.record && prev_gt) begin
         entry_in = prev_entry;
      end else if (ctl.record && gt) begin
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

### rtl/largest_allocation_tracker.sv
// Top level of the largest allocation tracker: a chain of ranked cells, the
// peak event register, the sequence counter and the response register.
// Depends on lat_pkg, lat_cell and assert_macros.svh.
//
// Usage: requests arrive on req_valid/req_ready/req_data and every request
// yields exactly one response on rsp_valid/rsp_ready/rsp_data.
// A record request stamps the event with the incremented sequence count,
// inserts it into the ranked table ahead of the first smaller entry and
// updates the peak event when its size is at least the stored peak size.
// A read request returns one table entry or, for slot TOP_ENTRIES, the peak
// event. A clear request zeroes the table, the peak and the counter.
// The response is registered and appears in the cycle after acceptance.
// One request per cycle unless the receiver stalls; all cells compare
// and shift in the same cycle, and the response register is the only stage.
// When the receiver stalls, the response register holds its request result
// and req_ready stays high only if that result is taken in the same cycle,
// so at most one response is ever waiting.
// Reset is synchronous and active high; it empties the response register
// and zeroes all tracked state, exactly like a clear request.
module largest_allocation_tracker #(
   parameter int TOP_ENTRIES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lat_pkg::rsp_type rsp_data
);
   import lat_pkg::*;

   `include "assert_macros.svh"

   localparam int IDX_W = $clog2(TOP_ENTRIES + 1);
   localparam int SEL_W = (IDX_W > 4) ? IDX_W : 4;
   // Rank reported when the event did not enter the table, cut to 4 bits.
   localparam logic [RANK_W-1:0] NO_RANK = RANK_W'(TOP_ENTRIES);

   logic             req_fire;
   logic             is_record;
   logic             is_read;
   logic             is_clear;
   logic [SEL_W-1:0] slot_ext;

   entry_type        new_entry;
   logic [31:0]      count_ff;
   logic [31:0]      count_in;
   entry_type        peak_ff;
   entry_type        peak_in;
   logic             peak_take;

   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   logic             cell_gt   [TOP_ENTRIES];
   logic             cell_prev [TOP_ENTRIES];
   entry_type        cell_ent  [TOP_ENTRIES];
   entry_type        cell_up   [TOP_ENTRIES];
   entry_type        cell_rd   [TOP_ENTRIES];
   cell_ctl_type     cell_ctl  [TOP_ENTRIES];

   entry_type        table_rd;
   logic [RANK_W-1:0] rank_or;
   logic [RANK_W-1:0] rank;

   // A new request may enter whenever the response register is empty or is
   // being emptied in this very cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_record = req_fire && (req_data.action == ACT_RECORD);
   assign is_read   = req_fire && (req_data.action == ACT_READ);
   assign is_clear  = req_fire && (req_data.action == ACT_CLEAR);
   assign slot_ext  = SEL_W'(req_data.slot);

   assign count_in = count_ff + 32'd1;

   always_comb begin
      new_entry             = '0;
      new_entry.bytes       = req_data.alloc_bytes;
      new_entry.want_type   = req_data.want_mem_type;
      new_entry.want_usage  = req_data.want_usage;
      new_entry.want_access = req_data.want_access;
      new_entry.got_type    = req_data.got_mem_type;
      new_entry.got_usage   = req_data.got_usage;
      new_entry.got_access  = req_data.got_access;
      new_entry.align       = req_data.align_bytes;
      new_entry.address     = req_data.buffer_address;
      new_entry.seq         = count_in;
   end

   // The chain of cells. Each cell sees its upper neighbor's compare result
   // and entry, so an insertion shifts everything below it by one place.
   for (genvar i = 0; i < TOP_ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_prev[i] = 1'b0;
         assign cell_up[i]   = '0;
      end else begin : g_link
         assign cell_prev[i] = cell_gt[i-1];
         assign cell_up[i]   = cell_ent[i-1];
      end

      assign cell_ctl[i].record = is_record;
      assign cell_ctl[i].clear  = is_clear;
      assign cell_ctl[i].rd_hit = is_read && (slot_ext == SEL_W'(i));

      lat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .new_entry  (new_entry),
         .prev_gt    (cell_prev[i]),
         .prev_entry (cell_up[i]),
         .gt         (cell_gt[i]),
         .entry      (cell_ent[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // Only the addressed cell drives nonzero read data, so the read mux is a
   // plain OR over the cells. The insertion rank is found the same way from
   // the one cell where the compare thermometer starts.
   always_comb begin
      table_rd = '0;
      rank_or  = '0;
      for (int i = 0; i < TOP_ENTRIES; i++) begin
         table_rd = table_rd | cell_rd[i];
         if (cell_gt[i] && !cell_prev[i]) begin
            rank_or = rank_or | RANK_W'(i);
         end
      end
   end

   assign rank = cell_gt[TOP_ENTRIES-1] ? rank_or : NO_RANK;

   // A zero-size event replaces the peak only while the peak size is zero.
   assign peak_take = new_entry.bytes >= peak_ff.bytes;

   always_comb begin
      peak_in = peak_ff;
      priority if (is_clear) begin
         peak_in = '0;
      end else if (is_record && peak_take) begin
         peak_in = new_entry;
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (req_data.action)
         ACT_RECORD: begin
            rsp_in.out_sequence  = count_in;
            rsp_in.rank_taken    = rank;
            rsp_in.peak_replaced = peak_take;
         end
         ACT_READ: begin
            if (slot_ext < SEL_W'(TOP_ENTRIES)) begin
               rsp_in = entry_to_rsp(table_rd);
            end else if (slot_ext == SEL_W'(TOP_ENTRIES)) begin
               rsp_in = entry_to_rsp(peak_ff);
            end
         end
         ACT_CLEAR: begin
            rsp_in = '0;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         peak_ff      <= peak_in;
         if (is_clear) begin
            count_ff <= '0;
         end else if (is_record) begin
            count_ff <= count_in;
         end
      end
   end

   // The payload register needs no reset; it is only seen while valid.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The ranked table never loses its non-increasing order.
   for (genvar i = 0; i + 1 < TOP_ENTRIES; i++) begin : g_order_chk
      `ASSERT_CLK(a_table_sorted, clock, reset,
                  cell_ent[i].bytes >= cell_ent[i+1].bytes, "ranked table out of order")
   end

   // The peak is the largest size seen since clear, so it bounds the table.
   `ASSERT_CLK(a_peak_bounds_table, clock, reset, peak_ff.bytes >= cell_ent[0].bytes,
               "peak smaller than top table entry")

   // A zero-size record never takes a table position.
   `ASSERT_CLK(a_zero_not_ranked, clock, reset,
               (is_record && (req_data.alloc_bytes == 64'd0)) |=>
               (rsp_valid_ff && (rsp_ff.rank_taken == NO_RANK)),
               "zero-size record was ranked")

   // Each record advances the sequence counter by exactly one.
   `ASSERT_CLK(a_count_step, clock, reset,
               is_record |=> (count_ff == ($past(count_ff) + 32'd1)),
               "sequence counter did not advance on record")

endmodule

### bench/lat_checker.sv
// Checker for the largest allocation tracker: watches both channels, keeps its own
// ranked table, peak event and sequence count, and compares every response.
// Depends on lat_pkg for the request and response types and the action codes.
module lat_checker #(
   parameter int TOP_ENTRIES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  lat_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  lat_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import lat_pkg::*;

   entry_type   ranked [TOP_ENTRIES];
   entry_type   peak_copy;
   logic [31:0] event_count;
   rsp_type     answers [$];

   function automatic void wipe_tracking();
      for (int i = 0; i < TOP_ENTRIES; i++) begin
         ranked[i] = '0;
      end
      peak_copy   = '0;
      event_count = '0;
   endfunction

   // Applies one request to the tracked state and returns the response it causes.
   function automatic rsp_type apply_request(req_type rq);
      rsp_type   rsp;
      entry_type ev;
      entry_type sel;
      logic      hit;
      int        pos;
      rsp = '0;
      sel = '0;
      hit = 1'b0;
      pos = TOP_ENTRIES;
      case (rq.action)
         ACT_RECORD: begin
            event_count    = event_count + 32'd1;
            ev.bytes       = rq.alloc_bytes;
            ev.want_type   = rq.want_mem_type;
            ev.want_usage  = rq.want_usage;
            ev.want_access = rq.want_access;
            ev.got_type    = rq.got_mem_type;
            ev.got_usage   = rq.got_usage;
            ev.got_access  = rq.got_access;
            ev.align       = rq.align_bytes;
            ev.address     = rq.buffer_address;
            ev.seq         = event_count;
            // Equal sizes stay ahead of the newcomer, so only a strictly smaller
            // entry gives up its place.
            if (ev.bytes != '0) begin
               for (int i = 0; i < TOP_ENTRIES; i++) begin
                  if (pos == TOP_ENTRIES && ev.bytes > ranked[i].bytes) begin
                     pos = i;
                  end
               end
               if (pos < TOP_ENTRIES) begin
                  for (int i = TOP_ENTRIES - 1; i > pos; i--) begin
                     ranked[i] = ranked[i-1];
                  end
                  ranked[pos] = ev;
               end
            end
            if (ev.bytes >= peak_copy.bytes) begin
               peak_copy         = ev;
               rsp.peak_replaced = 1'b1;
            end
            rsp.out_sequence = ev.seq;
            rsp.rank_taken   = pos[RANK_W-1:0];
         end
         ACT_READ: begin
            if (rq.slot < TOP_ENTRIES) begin
               sel = ranked[rq.slot];
               hit = 1'b1;
            end else if (rq.slot == TOP_ENTRIES) begin
               sel = peak_copy;
               hit = 1'b1;
            end
            if (hit) begin
               rsp.out_bytes       = sel.bytes;
               rsp.out_want_type   = sel.want_type;
               rsp.out_want_usage  = sel.want_usage;
               rsp.out_want_access = sel.want_access;
               rsp.out_got_type    = sel.got_type;
               rsp.out_got_usage   = sel.got_usage;
               rsp.out_got_access  = sel.got_access;
               rsp.out_align       = sel.align;
               rsp.out_address     = sel.address;
               rsp.out_sequence    = sel.seq;
            end
         end
         ACT_CLEAR: wipe_tracking();
         default: ;
      endcase
      return rsp;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         wipe_tracking();
         answers.delete();
      end else begin
         if (req_valid && req_ready) begin
            answers.push_back(apply_request(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (answers.size() == 0) begin
               $display("%0t ns: response with nothing expected, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = answers.pop_front();
               compare_field("out_bytes", want.out_bytes, rsp_data.out_bytes);
               compare_field("out_want_type", 64'(want.out_want_type),
                             64'(rsp_data.out_want_type));
               compare_field("out_want_usage", 64'(want.out_want_usage),
                             64'(rsp_data.out_want_usage));
               compare_field("out_want_access", 64'(want.out_want_access),
                             64'(rsp_data.out_want_access));
               compare_field("out_got_type", 64'(want.out_got_type),
                             64'(rsp_data.out_got_type));
               compare_field("out_got_usage", 64'(want.out_got_usage),
                             64'(rsp_data.out_got_usage));
               compare_field("out_got_access", 64'(want.out_got_access),
                             64'(rsp_data.out_got_access));
               compare_field("out_align", want.out_align, rsp_data.out_align);
               compare_field("out_address", want.out_address, rsp_data.out_address);
               compare_field("out_sequence", 64'(want.out_sequence),
                             64'(rsp_data.out_sequence));
               compare_field("rank_taken", 64'(want.rank_taken),
                             64'(rsp_data.rank_taken));
               compare_field("peak_replaced", 64'(want.peak_replaced),
                             64'(rsp_data.peak_replaced));
            end
         end
      end
      outstanding = answers.size();
   end

endmodule

### bench/tb_top.sv
// Top of the largest allocation tracker testbench: clock, reset, request and
// response drivers, and the final verdict.
// Depends on lat_pkg, largest_allocation_tracker and lat_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lat_pkg::*;

   localparam int         TOP_ENTRIES = 8;
   // The action encoding leaves one code unused; the block must answer it with zeros.
   localparam logic [1:0] ACT_UNUSED  = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;

   // Idle percentages for each side. The request side is read only by the main
   // process; the response side and the stall counter are shared with the
   // receiver, so they are written with nonblocking assignments.
   int req_idle_pct;
   int rsp_idle_pct;
   int stall_trigger;

   largest_allocation_tracker #(
      .TOP_ENTRIES(TOP_ENTRIES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   lat_checker #(
      .TOP_ENTRIES(TOP_ENTRIES)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #4 clock = ~clock;
      end
   end

   // A hung block must still end the run with a failure.
   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Record request for a given size; every other field is filled from one bit
   // pattern so that directed requests reach all-zero and all-one payloads.
   function automatic req_type sized_event(logic [63:0] bytes, logic [31:0] pat);
      req_type rq;
      rq.action         = ACT_RECORD;
      rq.slot           = pat[3:0];
      rq.alloc_bytes    = bytes;
      rq.want_mem_type  = pat;
      rq.want_usage     = ~pat;
      rq.want_access    = pat;
      rq.got_mem_type   = ~pat;
      rq.got_usage      = pat;
      rq.got_access     = ~pat;
      rq.align_bytes    = {pat, ~pat};
      rq.buffer_address = {~pat, pat};
      return rq;
   endfunction

   function automatic req_type read_of(int slot);
      req_type rq;
      rq        = '0;
      rq.action = ACT_READ;
      rq.slot   = slot[3:0];
      return rq;
   endfunction

   // Random request. Records dominate and most sizes are small, so equal sizes,
   // full tables and dropped entries come up often; clears are rare enough for
   // the table to fill between them.
   function automatic req_type random_request();
      req_type rq;
      int      pick;
      rq.want_mem_type  = $urandom;
      rq.want_usage     = $urandom;
      rq.want_access    = $urandom;
      rq.got_mem_type   = $urandom;
      rq.got_usage      = $urandom;
      rq.got_access     = $urandom;
      rq.align_bytes    = {$urandom, $urandom};
      rq.buffer_address = {$urandom, $urandom};
      rq.slot           = 4'($urandom_range(15));
      case ($urandom_range(9))
         0:       rq.alloc_bytes = '0;
         1:       rq.alloc_bytes = '1;
         2, 3:    rq.alloc_bytes = {$urandom, $urandom};
         4:       rq.alloc_bytes = 64'($urandom_range(4096));
         default: rq.alloc_bytes = 64'($urandom_range(24, 1));
      endcase
      pick = $urandom_range(99);
      if (pick < 60) begin
         rq.action = ACT_RECORD;
      end else if (pick < 94) begin
         rq.action = ACT_READ;
         // Reads mostly hit a table entry or the peak; the rest go past it.
         if ($urandom_range(99) < 85) begin
            rq.slot = 4'($urandom_range(TOP_ENTRIES));
         end else begin
            rq.slot = 4'($urandom_range(15, TOP_ENTRIES + 1));
         end
      end else if (pick < 98) begin
         rq.action = ACT_UNUSED;
      end else begin
         rq.action = ACT_CLEAR;
      end
      return rq;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   // Valid is only lowered during a gap, so it is never dropped and raised in
   // the same time step.
   task automatic offer_request(input req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // The sender goes quiet until every expected response has been taken.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic random_burst(input int count);
      for (int n = 0; n < count; n++) begin
         offer_request(random_request());
      end
   endtask

   // Receiver: random backpressure, plus a long hold-off whenever the main
   // process bumps the stall trigger. The hold-off is counted here so that the
   // sender keeps offering requests while the block fills up.
   initial begin : receiver
      int stall_left;
      int seen_trigger;
      stall_left   = 0;
      seen_trigger = 0;
      rsp_ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (seen_trigger != stall_trigger) begin
            seen_trigger = stall_trigger;
            stall_left   = 80;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      req_idle_pct  = 37;
      rsp_idle_pct  = 37;
      stall_trigger = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Reading the peak straight after reset must give zeros.
      offer_request(read_of(TOP_ENTRIES));
      // A zero-size record never enters the table but takes the empty peak,
      // and a second one takes it again since the stored size is still zero.
      offer_request(sized_event('0, '0));
      offer_request(sized_event('0, '1));
      // Equal sizes: the newer event ranks below the older one but wins the peak.
      offer_request(sized_event(64'd100, 32'hA5A5_A5A5));
      offer_request(sized_event(64'd100, 32'h5A5A_5A5A));
      offer_request(sized_event(64'd50, 32'h0F0F_0F0F));
      offer_request(sized_event('1, '1));
      offer_request(sized_event(64'd1, 32'hF0F0_F0F0));
      for (int s = 0; s <= TOP_ENTRIES; s++) begin
         offer_request(read_of(s));
      end
      // Slots past the peak read as zero.
      offer_request(read_of(TOP_ENTRIES + 1));
      offer_request(read_of(15));
      begin
         req_type odd;
         odd        = sized_event('1, '1);
         odd.action = ACT_UNUSED;
         offer_request(odd);
      end
      begin
         req_type wipe;
         wipe        = sized_event('1, '0);
         wipe.action = ACT_CLEAR;
         offer_request(wipe);
      end
      offer_request(read_of(0));
      offer_request(read_of(TOP_ENTRIES));
      offer_request(sized_event('0, 32'h1234_5678));

      // Random part with idling on both sides.
      random_burst(200);
      drain_responses();

      // A stretch with no idling at all: requests and responses back to back.
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      random_burst(120);

      // Long receiver hold-off while the sender keeps pushing.
      stall_trigger <= stall_trigger + 1;
      random_burst(30);
      drain_responses();

      req_idle_pct = 37;
      rsp_idle_pct <= 37;
      random_burst(200);

      drain_responses();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
